// ----- design/bnr_pkg.sv -----
`default_nettype none

package bnr_pkg;

  // Field and register widths.
  localparam int ParW  = 32;             // Q4.28 parameter and Q16.16 coordinate width
  localparam int AddrW = 5;              // byte address of eight 32-bit registers
  localparam int RegN  = 8;

  // Datapath widths.
  localparam int ValW   = 48;            // curve values and de Casteljau intermediates
  localparam int DifW   = ValW + 1;      // difference of two values
  localparam int SplitL = 24;            // low slice of a difference in the lerp multiply
  localparam int LpW    = ParW + DifW - SplitL;   // one lerp partial product
  localparam int LsW    = ParW + DifW;            // full lerp product
  localparam int FracT  = 28;            // fraction bits of the parameter
  localparam int SplitD = ValW / 2;      // slice of a value in the dot products
  localparam int DpW    = SplitD * 2 + 2;         // one dot-product partial product
  localparam int PrdW   = 96;            // exact products and their sums
  localparam int NumW   = 128;           // scaled dividend and partial remainders
  localparam int QuoW   = 35;            // quotient bits, two of them only flag overflow
  localparam int SumW   = ParW + 3;      // parameter plus step before saturation

  localparam int D1Scale = 3;            // first derivative control point scale
  localparam int D2Scale = 2;            // second derivative control point scale
  localparam longint RndHalf = longint'(1) << (FracT - 1);

  localparam logic signed [ParW-1:0] ParMax = 32'sh7FFF_FFFF;
  localparam logic signed [ParW-1:0] ParMin = 32'sh8000_0000;

  // Lerp pairing: each lerp takes element a and element a+1 of the previous level.
  localparam int L2Idx [6] = '{0, 1, 3, 4, 6, 8};
  localparam int L3Idx [2] = '{0, 2};
  // Dot-product operands: ex, ey, q1x, q1y, q2x, q2y.
  localparam int DotA [6] = '{0, 1, 2, 3, 0, 1};
  localparam int DotB [6] = '{2, 3, 2, 3, 4, 5};

  // Register map.
  typedef enum logic [2:0] {
    REG_CTRL0_X = 3'd0,
    REG_CTRL0_Y = 3'd1,
    REG_CTRL1_X = 3'd2,
    REG_CTRL1_Y = 3'd3,
    REG_CTRL2_X = 3'd4,
    REG_CTRL2_Y = 3'd5,
    REG_CTRL3_X = 3'd6,
    REG_CTRL3_Y = 3'd7
  } bnr_reg_e;

  typedef struct packed {
    logic signed [ParW-1:0] point_x;
    logic signed [ParW-1:0] point_y;
    logic signed [ParW-1:0] param_in;
  } bnr_in_t;

  typedef struct packed {
    logic signed [ParW-1:0] param_out;
    logic                   kept_old;
    logic                   clipped;
  } bnr_out_t;

  // Side data that travels with each item down the pipeline.
  typedef struct packed {
    logic signed [ParW-1:0] px;
    logic signed [ParW-1:0] py;
    logic signed [ParW-1:0] u;
    logic                   sgn;
    logic                   zero;
  } bnr_tag_t;

endpackage

`default_nettype wire

// ----- design/bezier_newton_reparameterize.sv -----
`default_nettype none

// Throughput: one item per cycle while the pipeline advances. There are 48 register
// stages, the last 35 of which are a restoring divider that resolves one quotient
// bit per stage.
// The pipeline advances while its last stage is empty or the output register can
// hand over, so new items enter while a finished result waits.
// Reset clears the control points to zero and empties the pipeline.
module bezier_newton_reparameterize (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bnr_pkg::bnr_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bnr_pkg::bnr_out_t              out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bnr_pkg::AddrW-1:0]      paddr,
  input  logic [bnr_pkg::ParW-1:0]       pwdata,
  output logic [bnr_pkg::ParW-1:0]       prdata,
  output logic                           pready
);
  import bnr_pkg::*;

  localparam int NS = 13 + QuoW;

  // Lerp helpers: difference, split multiply, and rounded accumulate.
  function automatic logic signed [DifW-1:0] dif_f(input logic signed [ValW-1:0] a,
                                                   input logic signed [ValW-1:0] b);
    dif_f = DifW'(b) - DifW'(a);
  endfunction

  function automatic logic signed [LpW-1:0] mul_lo_f(input logic signed [ParW-1:0] t,
                                                     input logic signed [DifW-1:0] d);
    logic signed [SplitL:0] dl;
    dl = $signed({1'b0, d[SplitL-1:0]});
    mul_lo_f = LpW'(t) * LpW'(dl);
  endfunction

  function automatic logic signed [LpW-1:0] mul_hi_f(input logic signed [ParW-1:0] t,
                                                     input logic signed [DifW-1:0] d);
    logic signed [DifW-SplitL-1:0] dh;
    dh = $signed(d[DifW-1:SplitL]);
    mul_hi_f = LpW'(t) * LpW'(dh);
  endfunction

  // a + t*(b-a)/2^28, rounded to nearest with ties away from zero.
  function automatic logic signed [ValW-1:0] acc_f(input logic signed [ValW-1:0] a,
                                                   input logic signed [LpW-1:0] pl,
                                                   input logic signed [LpW-1:0] ph);
    logic signed [LsW-1:0] p;
    logic signed [LsW-1:0] rnd;
    p   = (LsW'(ph) <<< SplitL) + LsW'(pl);
    rnd = p + (p[LsW-1] ? LsW'(RndHalf - 1) : LsW'(RndHalf));
    acc_f = a + ValW'(rnd >>> FracT);
  endfunction

  // Configuration registers.
  logic signed [ParW-1:0] ctrl_q [RegN];
  logic signed [ParW-1:0] ctrl_nx [RegN];

  assign pready = 1'b1;
  assign prdata = ctrl_q[paddr[AddrW-1:2]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegN; i++) ctrl_q[i] <= '0;
    end else if (psel && penable && pwrite) begin
      ctrl_q[paddr[AddrW-1:2]] <= pwdata;
    end
  end

  // Derivative control points and first-level lerp operands, derived from the register
  // values as they stand after this cycle's write, so the operand registers never lag.
  logic signed [ValW-1:0] cx [4];
  logic signed [ValW-1:0] cy [4];
  logic signed [ValW-1:0] d1x [3];
  logic signed [ValW-1:0] d1y [3];
  logic signed [ValW-1:0] d2x [2];
  logic signed [ValW-1:0] d2y [2];
  logic signed [ValW-1:0] c1a_d [12];
  logic signed [DifW-1:0] c1d_d [12];
  logic signed [ValW-1:0] c1a_q [12];
  logic signed [DifW-1:0] c1d_q [12];

  always_comb begin
    ctrl_nx = ctrl_q;
    if (psel && penable && pwrite) ctrl_nx[paddr[AddrW-1:2]] = pwdata;
    cx[0] = ValW'(ctrl_nx[REG_CTRL0_X]);
    cy[0] = ValW'(ctrl_nx[REG_CTRL0_Y]);
    cx[1] = ValW'(ctrl_nx[REG_CTRL1_X]);
    cy[1] = ValW'(ctrl_nx[REG_CTRL1_Y]);
    cx[2] = ValW'(ctrl_nx[REG_CTRL2_X]);
    cy[2] = ValW'(ctrl_nx[REG_CTRL2_Y]);
    cx[3] = ValW'(ctrl_nx[REG_CTRL3_X]);
    cy[3] = ValW'(ctrl_nx[REG_CTRL3_Y]);
    for (int i = 0; i < 3; i++) begin
      d1x[i] = (cx[i+1] - cx[i]) * ValW'(D1Scale);
      d1y[i] = (cy[i+1] - cy[i]) * ValW'(D1Scale);
    end
    for (int i = 0; i < 2; i++) begin
      d2x[i] = (d1x[i+1] - d1x[i]) * ValW'(D2Scale);
      d2y[i] = (d1y[i+1] - d1y[i]) * ValW'(D2Scale);
    end
    for (int j = 0; j < 3; j++) begin
      c1a_d[j]   = cx[j];
      c1d_d[j]   = dif_f(cx[j], cx[j+1]);
      c1a_d[3+j] = cy[j];
      c1d_d[3+j] = dif_f(cy[j], cy[j+1]);
    end
    for (int j = 0; j < 2; j++) begin
      c1a_d[6+j] = d1x[j];
      c1d_d[6+j] = dif_f(d1x[j], d1x[j+1]);
      c1a_d[8+j] = d1y[j];
      c1d_d[8+j] = dif_f(d1y[j], d1y[j+1]);
    end
    c1a_d[10] = d2x[0];
    c1d_d[10] = dif_f(d2x[0], d2x[1]);
    c1a_d[11] = d2y[0];
    c1d_d[11] = dif_f(d2y[0], d2y[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < 12; j++) begin
        c1a_q[j] <= '0;
        c1d_q[j] <= '0;
      end
    end else begin
      c1a_q <= c1a_d;
      c1d_q <= c1d_d;
    end
  end

  // Pipeline control: one advance signal for all stages.
  logic [NS-1:0] vld_q;
  logic          out_vld_q;
  logic          out_free;
  logic          adv;

  assign out_free   = !out_vld_q || out_ready_i;
  assign adv        = !vld_q[NS-1] || out_free;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) vld_q <= {vld_q[NS-2:0], in_valid_i};
      if (out_free) out_vld_q <= vld_q[NS-1];
    end
  end

  // Side data per stage; the signs and the zero test are settled at stage 11.
  bnr_tag_t tag_q [NS];
  bnr_tag_t tag_d [NS];

  // Payload registers.
  logic signed [ValW-1:0] m1a_q [12];
  logic signed [LpW-1:0]  m1l_q [12];
  logic signed [LpW-1:0]  m1h_q [12];
  logic signed [ValW-1:0] w1_q  [12];
  logic signed [ValW-1:0] m2a_q [6];
  logic signed [LpW-1:0]  m2l_q [6];
  logic signed [LpW-1:0]  m2h_q [6];
  logic signed [ValW-1:0] m2c_q [2];
  logic signed [ValW-1:0] w2_q  [6];
  logic signed [ValW-1:0] w2c_q [2];
  logic signed [ValW-1:0] m3a_q [2];
  logic signed [LpW-1:0]  m3l_q [2];
  logic signed [LpW-1:0]  m3h_q [2];
  logic signed [ValW-1:0] m3c_q [4];
  logic signed [ValW-1:0] w3_q  [2];
  logic signed [ValW-1:0] w3c_q [4];
  logic signed [ValW-1:0] e_q   [6];
  logic signed [DpW-1:0]  pp_d  [6][4];
  logic signed [DpW-1:0]  pp_q  [6][4];
  logic signed [PrdW-1:0] prod_q [6];
  logic signed [PrdW-1:0] num9_q;
  logic signed [PrdW-1:0] da_q;
  logic signed [PrdW-1:0] db_q;
  logic signed [PrdW-1:0] num10_q;
  logic signed [PrdW-1:0] den_q;
  logic [PrdW-1:0]        an_q;
  logic [PrdW-1:0]        ad_q;
  logic [NumW-1:0]        dv_rem_q [QuoW];
  logic [PrdW-1:0]        dv_den_q [QuoW];
  logic [QuoW-1:0]        dv_quo_q [QuoW+1];

  // Tag movement.
  always_comb begin
    tag_d[0].px   = in_data_i.point_x;
    tag_d[0].py   = in_data_i.point_y;
    tag_d[0].u    = in_data_i.param_in;
    tag_d[0].sgn  = 1'b0;
    tag_d[0].zero = 1'b0;
    for (int s = 1; s < NS; s++) tag_d[s] = tag_q[s-1];
    tag_d[11].sgn  = num10_q[PrdW-1] ^ den_q[PrdW-1];
    tag_d[11].zero = (den_q == '0);
  end

  // Dot-product partial products, split into signed high and unsigned low halves.
  always_comb begin
    logic signed [ValW-1:0] a;
    logic signed [ValW-1:0] b;
    logic signed [SplitD-1:0] ah;
    logic signed [SplitD-1:0] bh;
    logic signed [SplitD:0] al;
    logic signed [SplitD:0] bl;
    for (int i = 0; i < 6; i++) begin
      a  = e_q[DotA[i]];
      b  = e_q[DotB[i]];
      ah = $signed(a[ValW-1:SplitD]);
      bh = $signed(b[ValW-1:SplitD]);
      al = $signed({1'b0, a[SplitD-1:0]});
      bl = $signed({1'b0, b[SplitD-1:0]});
      pp_d[i][0] = DpW'(ah) * DpW'(bh);
      pp_d[i][1] = DpW'(ah) * DpW'(bl);
      pp_d[i][2] = DpW'(al) * DpW'(bh);
      pp_d[i][3] = DpW'(al) * DpW'(bl);
    end
  end

  // Divider: stage g decides quotient bit QuoW-1-g.
  logic [NumW-1:0] dv_sub [QuoW];
  logic            dv_take [QuoW];
  logic [QuoW-1:0] dv_quo_d [QuoW];

  always_comb begin
    for (int g = 0; g < QuoW; g++) begin
      dv_sub[g]  = NumW'(dv_den_q[g]) << (QuoW - 1 - g);
      dv_take[g] = dv_rem_q[g] >= dv_sub[g];
      dv_quo_d[g] = dv_quo_q[g];
      dv_quo_d[g][QuoW-1-g] = dv_take[g];
    end
  end

  // Datapath stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag_q <= tag_d;

      // Stage 0: first-level lerp multiplies against the register operands.
      for (int j = 0; j < 12; j++) begin
        m1a_q[j] <= c1a_q[j];
        m1l_q[j] <= mul_lo_f(in_data_i.param_in, c1d_q[j]);
        m1h_q[j] <= mul_hi_f(in_data_i.param_in, c1d_q[j]);
      end

      // Stage 1: first-level accumulate.
      for (int j = 0; j < 12; j++) w1_q[j] <= acc_f(m1a_q[j], m1l_q[j], m1h_q[j]);

      // Stage 2: second-level multiplies; the linear results pass on.
      for (int k = 0; k < 6; k++) begin
        m2a_q[k] <= w1_q[L2Idx[k]];
        m2l_q[k] <= mul_lo_f(tag_q[1].u, dif_f(w1_q[L2Idx[k]], w1_q[L2Idx[k]+1]));
        m2h_q[k] <= mul_hi_f(tag_q[1].u, dif_f(w1_q[L2Idx[k]], w1_q[L2Idx[k]+1]));
      end
      m2c_q[0] <= w1_q[10];
      m2c_q[1] <= w1_q[11];

      // Stage 3: second-level accumulate.
      for (int k = 0; k < 6; k++) w2_q[k] <= acc_f(m2a_q[k], m2l_q[k], m2h_q[k]);
      w2c_q <= m2c_q;

      // Stage 4: third-level multiplies for the curve point.
      for (int k = 0; k < 2; k++) begin
        m3a_q[k] <= w2_q[L3Idx[k]];
        m3l_q[k] <= mul_lo_f(tag_q[3].u, dif_f(w2_q[L3Idx[k]], w2_q[L3Idx[k]+1]));
        m3h_q[k] <= mul_hi_f(tag_q[3].u, dif_f(w2_q[L3Idx[k]], w2_q[L3Idx[k]+1]));
      end
      m3c_q[0] <= w2_q[4];
      m3c_q[1] <= w2_q[5];
      m3c_q[2] <= w2c_q[0];
      m3c_q[3] <= w2c_q[1];

      // Stage 5: curve point.
      for (int k = 0; k < 2; k++) w3_q[k] <= acc_f(m3a_q[k], m3l_q[k], m3h_q[k]);
      w3c_q <= m3c_q;

      // Stage 6: error vector from the sample point.
      e_q[0] <= w3_q[0] - ValW'(tag_q[5].px);
      e_q[1] <= w3_q[1] - ValW'(tag_q[5].py);
      for (int k = 0; k < 4; k++) e_q[2+k] <= w3c_q[k];

      // Stage 7: partial products.
      pp_q <= pp_d;

      // Stage 8: full products.
      for (int i = 0; i < 6; i++) begin
        prod_q[i] <= (PrdW'(pp_q[i][0]) <<< (2 * SplitD))
                   + ((PrdW'(pp_q[i][1]) + PrdW'(pp_q[i][2])) <<< SplitD)
                   + PrdW'(pp_q[i][3]);
      end

      // Stages 9 and 10: numerator and denominator sums.
      num9_q  <= prod_q[0] + prod_q[1];
      da_q    <= prod_q[2] + prod_q[3];
      db_q    <= prod_q[4] + prod_q[5];
      num10_q <= num9_q;
      den_q   <= da_q + db_q;

      // Stage 11: magnitudes.
      an_q <= num10_q[PrdW-1] ? PrdW'(-num10_q) : PrdW'(num10_q);
      ad_q <= den_q[PrdW-1] ? PrdW'(-den_q) : PrdW'(den_q);

      // Stage 12: scaled dividend with half the divisor added for rounding.
      dv_rem_q[0] <= (NumW'(an_q) << FracT) + NumW'(ad_q >> 1);
      dv_den_q[0] <= ad_q;
      dv_quo_q[0] <= '0;

      // Stages 13 on: one restoring step each; the last step keeps only its quotient.
      for (int g = 0; g < QuoW - 1; g++) begin
        dv_rem_q[g+1] <= dv_take[g] ? dv_rem_q[g] - dv_sub[g] : dv_rem_q[g];
        dv_den_q[g+1] <= dv_den_q[g];
      end
      for (int g = 0; g < QuoW; g++) dv_quo_q[g+1] <= dv_quo_d[g];
    end
  end

  // Final step, saturation and the output register.
  bnr_tag_t               tl;
  logic [QuoW-1:0]        quo;
  logic signed [SumW-1:0] step;
  logic signed [SumW-1:0] sum;
  bnr_out_t               out_d;
  bnr_out_t               out_q;

  always_comb begin
    tl   = tag_q[NS-1];
    quo  = dv_quo_q[QuoW];
    step = $signed({2'b00, quo[QuoW-3:0]});
    sum  = tl.sgn ? SumW'(tl.u) + step : SumW'(tl.u) - step;
    out_d.kept_old = 1'b0;
    out_d.clipped  = 1'b0;
    out_d.param_out = ParW'(sum);
    if (tl.zero) begin
      out_d.param_out = tl.u;
      out_d.kept_old  = 1'b1;
    end else if (quo[QuoW-1] || quo[QuoW-2]) begin
      out_d.param_out = tl.sgn ? ParMax : ParMin;
      out_d.clipped   = 1'b1;
    end else if (sum > SumW'(ParMax)) begin
      out_d.param_out = ParMax;
      out_d.clipped   = 1'b1;
    end else if (sum < SumW'(ParMin)) begin
      out_d.param_out = ParMin;
      out_d.clipped   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && vld_q[NS-1]) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.kept_old && out_data_o.clipped))
    else $error("kept_old and clipped both set");

  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clipped |->
      (out_data_o.param_out == ParMax || out_data_o.param_out == ParMin))
    else $error("clipped result is not at a range limit");

  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS-1] && out_vld_q && !out_ready_i |=> vld_q[NS-1])
    else $error("last pipeline stage dropped an item while the output stalled");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted item did not enter the first stage");
`endif

endmodule

`default_nettype wire
